### hdl/sts_pkg.sv
// Shared types and constants for the sine Taylor series unit.
// No dependencies.
package sts_pkg;
  localparam int MAX_TERM_INDEX = 9;
  localparam int FRAC_BITS = 24;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;
  localparam int MAG_W = 48;

  localparam logic [3:0] REG_TERM_LIMIT = 4'd0;
  localparam logic [3:0] REG_ACCURACY = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_FIRST, ST_MUL1, ST_MUL2, ST_DIV, ST_ACC, ST_DONE
  } sts_state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic first;
    logic mul1;
    logic mul2;
    logic div_start;
    logic acc;
  } sts_cmd_t;

  typedef struct packed {
    logic reduce_done;
    logic div_done;
    logic below_acc;
  } sts_stat_t;

  // round(2*pi * 2^frac) from the Q61 constant, half up
  function automatic logic [63:0] two_pi_fx(input int frac);
    logic [63:0] r;
    r = (TWO_PI_Q61 + (64'd1 << (61 - frac - 1))) >> (61 - frac);
    return r;
  endfunction
endpackage

### hdl/sts_ctrl.sv
// Sequencer for the sine Taylor series unit.
// Depends on sts_pkg.
module sts_ctrl #(
  parameter int MAX_TERM_INDEX = sts_pkg::MAX_TERM_INDEX
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [3:0]       term_limit,
  input  logic             acc_enable,
  input  sts_pkg::sts_stat_t stat,
  output sts_pkg::sts_cmd_t  cmd,
  output logic             busy,
  output logic             done,
  output logic [3:0]       term_k,
  output logic             hit
);
  import sts_pkg::*;

  sts_state_t state, state_next;
  logic [3:0] limit;
  logic       last_term, stop;

  assign last_term = (term_k == limit);
  assign stop = acc_enable && stat.below_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term_k <= '0;
      limit <= '0;
      hit <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        term_k <= '0;
        hit <= 1'b0;
        limit <= (term_limit > 4'(MAX_TERM_INDEX)) ? 4'(MAX_TERM_INDEX) : term_limit;
      end
      if (state == ST_ACC) begin
        if (stop) hit <= 1'b1;
        else if (!last_term) term_k <= term_k + 4'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_REDUCE;
      ST_REDUCE: if (stat.reduce_done) state_next = ST_FIRST;
      ST_FIRST:  state_next = ST_ACC;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_DIV;
      ST_DIV:    if (stat.div_done) state_next = ST_ACC;
      ST_ACC:    state_next = (stop || last_term) ? ST_DONE : ST_MUL1;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == ST_IDLE) && start;
    cmd.reduce = (state == ST_REDUCE);
    cmd.first = (state == ST_FIRST);
    cmd.mul1 = (state == ST_MUL1);
    cmd.mul2 = (state == ST_MUL2);
    cmd.div_start = (state == ST_MUL2);
    cmd.acc = (state == ST_ACC);
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
endmodule

### hdl/sts_divider.sv
// Divider by the term constant (2k)(2k+1): reciprocal multiply in two halves,
// rounds half up. Depends on sts_pkg.
module sts_divider #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sts_pkg::MAG_W-1:0] dividend,
  input  logic [8:0]                divisor,
  input  logic [3:0]                term_k,
  output logic                      done,
  output logic [sts_pkg::MAG_W-1:0] quotient
);
  import sts_pkg::*;

  // dividend plus half divisor stays below 2^N_W for any reduced angle
  localparam int N_W = FRAC_BITS + 13;
  localparam int SHIFT = N_W + 9;
  localparam int R_W = SHIFT - 2;
  localparam int LO_W = R_W / 2;
  localparam int HI_W = R_W - LO_W;
  localparam int QSH = SHIFT - LO_W;
  localparam int T_W = N_W + HI_W + 1;

  // ceil(2^SHIFT / d): exact floor for every dividend below 2^N_W
  function automatic logic [R_W-1:0] recip(input int d);
    logic [63:0] r;
    r = ((64'd1 << SHIFT) + 64'(d) - 64'd1) / 64'(d);
    return R_W'(r);
  endfunction

  localparam logic [R_W-1:0] RCP_1 = recip(6);
  localparam logic [R_W-1:0] RCP_2 = recip(20);
  localparam logic [R_W-1:0] RCP_3 = recip(42);
  localparam logic [R_W-1:0] RCP_4 = recip(72);
  localparam logic [R_W-1:0] RCP_5 = recip(110);
  localparam logic [R_W-1:0] RCP_6 = recip(156);
  localparam logic [R_W-1:0] RCP_7 = recip(210);
  localparam logic [R_W-1:0] RCP_8 = recip(272);
  localparam logic [R_W-1:0] RCP_9 = recip(342);

  logic [N_W-1:0]      num;
  logic [R_W-1:0]      rcp, rcp_sel;
  logic [N_W-1:0]      part;
  logic                phase, running;
  logic [HI_W-1:0]     mul_b;
  logic [T_W-2:0]      prod;
  logic [T_W-1:0]      total;

  always_comb begin
    case (term_k)
      4'd1:    rcp_sel = RCP_1;
      4'd2:    rcp_sel = RCP_2;
      4'd3:    rcp_sel = RCP_3;
      4'd4:    rcp_sel = RCP_4;
      4'd5:    rcp_sel = RCP_5;
      4'd6:    rcp_sel = RCP_6;
      4'd7:    rcp_sel = RCP_7;
      4'd8:    rcp_sel = RCP_8;
      4'd9:    rcp_sel = RCP_9;
      default: rcp_sel = '0;
    endcase
  end

  // low half of the reciprocal first, then the high half
  assign mul_b = phase ? HI_W'(rcp[R_W-1:LO_W]) : HI_W'(rcp[LO_W-1:0]);
  assign prod = (T_W-1)'(num) * (T_W-1)'(mul_b);
  assign total = T_W'(prod) + T_W'(part);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        phase <= 1'b0;
        // (v + d/2) / d
        num <= N_W'(dividend + MAG_W'(divisor >> 1));
        rcp <= rcp_sel;
      end else if (running) begin
        if (!phase) begin
          part <= prod[N_W+LO_W-1:LO_W];
          phase <= 1'b1;
        end else begin
          quotient <= MAG_W'(total >> QSH);
          phase <= 1'b0;
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/sts_datapath.sv
// Datapath: range reduction, term recurrence and running sum.
// Depends on sts_pkg and sts_divider.
module sts_datapath #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  sts_pkg::sts_cmd_t  cmd,
  input  logic [31:0]        angle,
  input  logic [30:0]        accuracy,
  input  logic [3:0]         term_k,
  output sts_pkg::sts_stat_t stat,
  output logic [31:0]        sine_value
);
  import sts_pkg::*;

  localparam logic signed [33:0] TWO_PI = 34'(two_pi_fx(FRAC_BITS));
  // |x| <= 2*pi, terms below 82, first product below 516
  localparam int M_W = FRAC_BITS + 3;
  localparam int A_W = FRAC_BITS + 10;
  localparam int P_W = A_W + M_W;

  logic signed [33:0] x;
  logic [M_W-1:0]     m;
  logic [MAG_W-1:0]   mag, prod, prod_next;
  logic signed [52:0] sum;
  logic               neg_x;
  logic [MAG_W-1:0]   quo;
  logic               div_done;
  logic [A_W-1:0]     mul_a;
  logic [P_W-1:0]     mul_full;
  logic [8:0]         divisor;
  logic [4:0]         two_k;
  logic               term_neg;

  assign two_k = {term_k, 1'b0};
  assign divisor = 9'(two_k) * (9'(two_k) + 9'd1);
  assign mul_a = cmd.mul1 ? A_W'(mag) : A_W'(prod);
  assign mul_full = P_W'(mul_a) * P_W'(m);
  assign prod_next = MAG_W'((mul_full + (P_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.load) x <= 34'(signed'(angle));
    else if (cmd.reduce) begin
      if (x > TWO_PI) x <= x - TWO_PI;
      else if (x < -TWO_PI) x <= x + TWO_PI;
    end
    if (cmd.first) begin
      neg_x <= x[33];
      m <= x[33] ? M_W'(-x) : M_W'(x);
      mag <= x[33] ? MAG_W'(-x) : MAG_W'(x);
    end
    if (cmd.mul1 || cmd.mul2)
      prod <= prod_next;
    if (div_done) mag <= quo;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sum <= '0;
    else if (cmd.acc) begin
      if (term_neg) sum <= sum - 53'(mag);
      else sum <= sum + 53'(mag);
    end
  end

  assign term_neg = neg_x ^ term_k[0];

  // divider takes the second product as it is formed
  sts_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(prod_next),
    .divisor(divisor), .term_k(term_k), .done(div_done), .quotient(quo)
  );

  assign stat.reduce_done = !(x > TWO_PI) && !(x < -TWO_PI);
  assign stat.div_done = div_done;
  assign stat.below_acc = (mag < MAG_W'(accuracy));

  always_comb begin
    if (sum > 53'sh7FFFFFFF) sine_value = 32'h7FFFFFFF;
    else if (sum < -53'sh80000000) sine_value = 32'h80000000;
    else sine_value = sum[31:0];
  end
endmodule

### hdl/sine_taylor_series_approx_unit.sv
// Top level of the sine Taylor series unit.
// Depends on sts_pkg, sts_ctrl, sts_datapath, sts_divider.
//
// One angle word in (signed Q8.24 radians), one result word out. Pulse start
// while busy is low; the result appears on sine_value, terms_used and
// threshold_hit for exactly one cycle with done high and cannot be held off.
// The run takes R reduction steps (one add or subtract of 2*pi per cycle,
// about |angle|/2*pi, at most 20), then per extra term two products on the
// shared multiplier, a division in the reciprocal divider and an accumulate
// step. A new start is taken once the unit is back in idle after done.
// Registers (to be written only when idle; the block does not enforce this):
// index 0 term_limit (clamped to 9), index 1 accuracy (0 turns off early
// stop).
module sine_taylor_series_approx_unit #(
  parameter int MAX_TERM_INDEX = sts_pkg::MAX_TERM_INDEX,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [31:0] angle,
  output logic        done,
  output logic [31:0] sine_value,
  output logic [3:0]  terms_used,
  output logic        threshold_hit
);
  import sts_pkg::*;

  logic [3:0]  term_limit;
  logic [30:0] accuracy;
  sts_cmd_t    cmd;
  sts_stat_t   stat;
  logic [3:0]  term_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit <= 4'd9;
      accuracy <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TERM_LIMIT: term_limit <= cfg_data[3:0];
        REG_ACCURACY:   accuracy <= cfg_data;
        default: ;
      endcase
    end
  end

  sts_ctrl #(.MAX_TERM_INDEX(MAX_TERM_INDEX)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .term_limit(term_limit),
    .acc_enable(accuracy != '0), .stat(stat), .cmd(cmd), .busy(busy),
    .done(done), .term_k(term_k), .hit(threshold_hit)
  );

  sts_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .angle(angle), .accuracy(accuracy),
    .term_k(term_k), .stat(stat), .sine_value(sine_value)
  );

  assign terms_used = term_k + 4'd1;
endmodule

### hdl/sts_checker.sv
// Port-level checks for the sine Taylor series unit, bound to the top.
// Depends on sine_taylor_series_approx_unit.
module sts_port_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] terms_used
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_terms: assert property (@(posedge clk) disable iff (rst)
    done |-> terms_used >= 4'd1 && terms_used <= 4'd10) else $error("terms_used");
endmodule

bind sine_taylor_series_approx_unit sts_port_props u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .terms_used(terms_used)
);

### tb/sts_checker.sv
// Checker for the sine Taylor series unit: predicts each result word and compares.
// Depends on sts_pkg; watches the DUT ports from the testbench top.
`timescale 1ns / 100ps
module sts_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [31:0] angle,
  input  logic        done,
  input  logic [31:0] sine_value,
  input  logic [3:0]  terms_used,
  input  logic        threshold_hit,
  output int          fail_count,
  output int          pending
);
  import sts_pkg::*;

  typedef struct packed {
    logic [31:0] sine;
    logic [3:0]  terms;
    logic        hit;
  } sine_word_t;

  sine_word_t  sine_q[$];
  logic [3:0]  lim_reg;
  logic [30:0] acc_reg;

  function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b + (128'd1 << (FRAC_BITS - 1));
    return p[63+FRAC_BITS:FRAC_BITS];
  endfunction

  function automatic sine_word_t sine_series(input logic [31:0] ang);
    sine_word_t  r;
    longint      x, sum, tp;
    logic [63:0] m, mag, v, d;
    int          lim, k;
    logic        neg;
    tp = longint'((TWO_PI_Q61 + (64'd1 << (61 - FRAC_BITS - 1))) >> (61 - FRAC_BITS));
    x = longint'($signed(ang));
    if (x > 0) while (x > tp) x -= tp;
    else if (x < 0) while (x < -tp) x += tp;
    m = (x < 0) ? -x : x;
    lim = (lim_reg > MAX_TERM_INDEX) ? MAX_TERM_INDEX : lim_reg;
    sum = 0; mag = 0; r.hit = 0; r.terms = 0;
    for (k = 0; k <= lim; k++) begin
      if (k == 0) mag = m;
      else begin
        d = 64'((2 * k) * (2 * k + 1));
        v = round_mul(round_mul(mag, m), m);
        mag = (v + d / 2) / d;
      end
      neg = (x < 0) != k[0];
      if (neg) sum -= longint'(mag);
      else sum += longint'(mag);
      r.terms = 4'(k + 1);
      if (acc_reg != 0 && mag < acc_reg) begin
        r.hit = 1;
        break;
      end
    end
    if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
    if (sum < -64'sh80000000) sum = -64'sh80000000;
    r.sine = sum[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    sine_word_t exp_w;
    if (rst) begin
      lim_reg <= 4'd9;
      acc_reg <= '0;
      fail_count <= 0;
      pending <= 0;
      sine_q.delete();
    end else begin
      if (cfg_we && cfg_index == REG_TERM_LIMIT) lim_reg <= cfg_data[3:0];
      if (cfg_we && cfg_index == REG_ACCURACY) acc_reg <= cfg_data;
      if (start && !busy) sine_q.push_back(sine_series(angle));
      if (done) begin
        if (sine_q.size() == 0) begin
          $display("%0t: unexpected word sine=%h terms=%0d hit=%0b", $time,
                   sine_value, terms_used, threshold_hit);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = sine_q.pop_front();
          if (exp_w != {sine_value, terms_used, threshold_hit}) begin
            $display("%0t: mismatch exp sine=%h terms=%0d hit=%0b act sine=%h terms=%0d hit=%0b",
                     $time, exp_w.sine, exp_w.terms, exp_w.hit,
                     sine_value, terms_used, threshold_hit);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= sine_q.size();
    end
  end
endmodule

### tb/tb_sine_taylor_series_approx_unit.sv
// Testbench top for the sine Taylor series unit: stimulus, config phases, verdict.
// Depends on sts_pkg, sine_taylor_series_approx_unit and sts_checker.
`timescale 1ns / 100ps
module tb_sine_taylor_series_approx_unit;
  import sts_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        cfg_we = 0;
  logic [3:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic [31:0] angle = '0;
  logic        busy, done, threshold_hit;
  logic [31:0] sine_value;
  logic [3:0]  terms_used;
  int          fail_count, pending;

  always #6 clk = ~clk;

  sine_taylor_series_approx_unit DUT (.*);
  sts_checker u_chk (.*);

  // 2*pi in Q8.24, for angles on the reduction boundary
  localparam logic [31:0] TWO_PI_Q24 = 32'h06487ED5;

  // one angle word: optional random gap, wait for idle, pulse start for one cycle
  task automatic send_angle(input logic [31:0] a, input bit gap);
    int n;
    n = gap ? $urandom_range(0, 18) : 0;
    repeat (n) @(negedge clk);
    while (busy) @(negedge clk);
    angle <= a;
    start <= 1;
    @(negedge clk);
    start <= 0;
    angle <= $urandom;
  endtask

  // drain, let the block settle, then write one register
  task automatic write_reg(input logic [3:0] idx, input logic [30:0] val);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // mostly in-range angles, some anywhere, some near 2*pi multiples
  function automatic logic [31:0] pick_angle();
    int s;
    s = $urandom_range(0, 9);
    if (s < 5) return $signed($urandom_range(0, 32'h0C90FDAA)) - 32'sh06487ED5;
    if (s < 8) return $urandom;
    return TWO_PI_Q24 * $urandom_range(1, 20) + $urandom_range(0, 2) - 1;
  endfunction

  initial begin
    logic [31:0] dir[$];
    int ph, i;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: extremes, zero, boundaries of reduction
    dir = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF,
            TWO_PI_Q24, TWO_PI_Q24 + 1, -TWO_PI_Q24, -TWO_PI_Q24 - 1,
            32'h01921FB5, 32'hFE6DE04B, 32'h03243F6A, 32'h55555555, 32'hAAAAAAAA};
    foreach (dir[j]) send_angle(dir[j], 0);
    write_reg(REG_TERM_LIMIT, 4'd15);   // above 9: clamps
    write_reg(REG_ACCURACY, 31'h7FFFFFFF);
    send_angle(32'h0, 0);
    send_angle(32'h7FFFFFFF, 0);
    write_reg(REG_ACCURACY, 31'd1);     // zero angle stops on first term
    send_angle(32'h0, 0);
    send_angle(32'h01000000, 0);
    write_reg(REG_TERM_LIMIT, 4'd0);
    send_angle(32'h80000000, 0);
    send_angle(32'h02000000, 0);
    // random phases over settings
    for (ph = 0; ph < 9; ph++) begin
      write_reg(REG_TERM_LIMIT, (ph == 0) ? 4'd0 : (ph == 1) ? 4'd9 : $urandom_range(0, 15));
      write_reg(REG_ACCURACY, (ph < 3) ? 31'd0 : (ph == 3) ? 31'h7FFFFFFF :
                (ph[0] ? $urandom_range(1, 4096) : $urandom & 31'h7FFFFFFF));
      for (i = 0; i < 50; i++) send_angle(pick_angle(), ph != 4);
    end
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("CHECK FAILED");
    $finish;
  end
endmodule

### sine_taylor_series_approx_unit.f
hdl/sts_pkg.sv
hdl/sts_ctrl.sv
hdl/sts_divider.sv
hdl/sts_datapath.sv
hdl/sine_taylor_series_approx_unit.sv
hdl/sts_checker.sv
tb/sts_checker.sv
tb/tb_sine_taylor_series_approx_unit.sv
